>>> rtl/core/sorted_primary_key_index_macros.svh
// assertion macros for the sorted primary key index
`ifndef SORTED_PRIMARY_KEY_INDEX_MACROS_SVH
`define SORTED_PRIMARY_KEY_INDEX_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on the rising clock outside reset
`define SPKI_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("spki assertion failed");
// next-cycle implication
`define SPKI_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("spki assertion failed");
`else
`define SPKI_ASSERT_IMP(lbl, ante, cons)
`define SPKI_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

>>> rtl/core/spki_pkg.sv
// types, constants and helpers shared by the sorted index table
`timescale 1ns / 1ps
`default_nettype none

package spki_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int KEY_BYTES   = 12;

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int CW    = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W = 96;
    localparam int OFF_W = 32;
    localparam int RAM_W = KEY_W + OFF_W;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_DELETE = 2'd1;
    localparam logic [1:0] KIND_LOOKUP = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_DUPLICATE = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] key_head;
        logic [31:0] key_tail;
        logic [31:0] record_offset;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  position;
        logic [31:0] found_offset;
        logic [6:0]  entries_used;
    } t_rsp;

    typedef struct packed {
        logic             wr_en;
        logic [AW-1:0]    wr_addr;
        logic [RAM_W-1:0] wr_data;
        logic [AW-1:0]    rd_addr;
    } t_ram_cmd;

    typedef struct packed {
        logic          busy;
        logic          done;
        logic [CW-1:0] count;
    } t_ctl_stat;

    // clear bytes beyond the key length and everything after the first zero byte
    function automatic logic [KEY_W-1:0] norm_key(input logic [KEY_W-1:0] raw);
        logic [KEY_W-1:0] res;
        logic             ended;
        logic [7:0]       b;
        res   = '0;
        ended = 1'b0;
        for (int i = 0; i < KEY_W / 8; i++) begin
            b = raw[KEY_W-1-8*i -: 8];
            if (i >= KEY_BYTES || ended) begin
                b = 8'd0;
            end
            if (b == 8'd0) begin
                ended = 1'b1;
            end
            res[KEY_W-1-8*i -: 8] = b;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/spki_ram.sv
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module spki_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

>>> rtl/core/spki_ctrl.sv
// sequencer: binary search, hit probe and entry shifting over the table ram
`timescale 1ns / 1ps
`default_nettype none

module spki_ctrl
    import spki_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_req_valid,
    input  wire t_req             i_req,
    input  wire logic             i_rsp_stall,
    input  wire logic [RAM_W-1:0] i_rd_data,
    output t_ram_cmd              o_ram,
    output t_ctl_stat             o_stat,
    output t_rsp                  o_rsp
);

    typedef enum logic [3:0] {
        S_IDLE, S_SRCH, S_CMP, S_PROBE, S_ACT,
        S_UP_RD, S_UP_WR, S_DN_RD, S_DN_WR, S_DONE
    } t_state;

    t_state           r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_lo, n_lo;
    logic [CW-1:0]    r_hi, n_hi;
    logic [CW-1:0]    r_idx, n_idx;
    logic [AW-1:0]    r_mid, n_mid;
    logic [1:0]       r_kind, n_kind;
    logic [KEY_W-1:0] r_key, n_key;
    logic [OFF_W-1:0] r_off, n_off;
    logic             r_hit, n_hit;
    logic [OFF_W-1:0] r_probe_off, n_probe_off;
    logic [1:0]       r_status, n_status;
    logic [AW-1:0]    r_pos, n_pos;
    logic [OFF_W-1:0] r_found, n_found;

    logic [CW:0]      w_sum;
    logic [CW-1:0]    w_idx_dec;
    logic [CW-1:0]    w_idx_inc;
    logic [KEY_W-1:0] w_rd_key;
    logic [OFF_W-1:0] w_rd_off;

    assign w_sum     = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_idx_dec = r_idx - CW'(1);
    assign w_idx_inc = r_idx + CW'(1);
    assign w_rd_key  = i_rd_data[RAM_W-1:OFF_W];
    assign w_rd_off  = i_rd_data[OFF_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_idx       = r_idx;
        n_mid       = r_mid;
        n_kind      = r_kind;
        n_key       = r_key;
        n_off       = r_off;
        n_hit       = r_hit;
        n_probe_off = r_probe_off;
        n_status    = r_status;
        n_pos       = r_pos;
        n_found     = r_found;
        o_ram       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_kind  = i_req.kind;
                    n_key   = norm_key({i_req.key_head, i_req.key_tail});
                    n_off   = i_req.record_offset;
                    n_lo    = '0;
                    n_hi    = r_count;
                    n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                if (r_lo < r_hi) begin
                    n_mid         = w_sum[AW:1];
                    o_ram.rd_addr = w_sum[AW:1];
                    n_state       = S_CMP;
                end else begin
                    o_ram.rd_addr = r_lo[AW-1:0];
                    n_state       = S_PROBE;
                end
            end
            S_CMP: begin
                if (w_rd_key < r_key) begin
                    n_lo = CW'(r_mid) + CW'(1);
                end else begin
                    n_hi = CW'(r_mid);
                end
                n_state = S_SRCH;
            end
            S_PROBE: begin
                n_hit       = (r_lo < r_count) && (w_rd_key == r_key);
                n_probe_off = w_rd_off;
                n_state     = S_ACT;
            end
            S_ACT: begin
                n_status = ST_NOT_FOUND;
                n_pos    = '0;
                n_found  = '0;
                n_state  = S_DONE;
                case (r_kind)
                    KIND_INSERT: begin
                        if (r_hit) begin
                            n_status = ST_DUPLICATE;
                            n_pos    = r_lo[AW-1:0];
                        end else if (r_count >= CW'(TABLE_DEPTH)) begin
                            n_status = ST_FULL;
                        end else begin
                            n_idx   = r_count;
                            n_state = S_UP_RD;
                        end
                    end
                    KIND_DELETE: begin
                        if (r_hit) begin
                            n_idx   = r_lo;
                            n_state = S_DN_RD;
                        end
                    end
                    KIND_LOOKUP: begin
                        if (r_hit) begin
                            n_status = ST_OK;
                            n_pos    = r_lo[AW-1:0];
                            n_found  = r_probe_off;
                        end
                    end
                    default: begin
                        n_status = ST_NOT_FOUND;
                    end
                endcase
            end
            S_UP_RD: begin
                if (r_idx > r_lo) begin
                    o_ram.rd_addr = w_idx_dec[AW-1:0];
                    n_state       = S_UP_WR;
                end else begin
                    o_ram.wr_en   = 1'b1;
                    o_ram.wr_addr = r_lo[AW-1:0];
                    o_ram.wr_data = {r_key, r_off};
                    n_count       = r_count + CW'(1);
                    n_status      = ST_OK;
                    n_pos         = r_lo[AW-1:0];
                    n_state       = S_DONE;
                end
            end
            S_UP_WR: begin
                o_ram.wr_en   = 1'b1;
                o_ram.wr_addr = r_idx[AW-1:0];
                o_ram.wr_data = i_rd_data;
                n_idx         = w_idx_dec;
                n_state       = S_UP_RD;
            end
            S_DN_RD: begin
                if (w_idx_inc < r_count) begin
                    o_ram.rd_addr = w_idx_inc[AW-1:0];
                    n_state       = S_DN_WR;
                end else begin
                    n_count  = r_count - CW'(1);
                    n_status = ST_OK;
                    n_pos    = r_lo[AW-1:0];
                    n_state  = S_DONE;
                end
            end
            S_DN_WR: begin
                o_ram.wr_en   = 1'b1;
                o_ram.wr_addr = r_idx[AW-1:0];
                o_ram.wr_data = i_rd_data;
                n_idx         = w_idx_inc;
                n_state       = S_DN_RD;
            end
            S_DONE: begin
                if (!i_rsp_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_idx       <= n_idx;
        r_mid       <= n_mid;
        r_kind      <= n_kind;
        r_key       <= n_key;
        r_off       <= n_off;
        r_hit       <= n_hit;
        r_probe_off <= n_probe_off;
        r_status    <= n_status;
        r_pos       <= n_pos;
        r_found     <= n_found;
    end

    assign o_stat.busy  = (r_state != S_IDLE);
    assign o_stat.done  = (r_state == S_DONE);
    assign o_stat.count = r_count;

    assign o_rsp.status       = r_status;
    assign o_rsp.position     = 6'(r_pos);
    assign o_rsp.found_offset = r_found;
    assign o_rsp.entries_used = 7'(r_count);

endmodule

`default_nettype wire

>>> rtl/core/sorted_primary_key_index.sv
// top level of the sorted primary key index table
//
//  channel   valid     stall     payload   direction
//  request   i_valid   o_stall   i_req     in
//  result    o_valid   i_stall   o_rsp     out
//
// one request at a time; the sequencer runs in the single table ram port pair
// steps: accept, a read and compare per binary search step (up to 7), probe read and decide,
//   a read and write per shifted entry on insert or delete, a write on insert, hand-off
// the shift over the table ram sets the worst case
// reset clears the state machine and the entry count; ram contents need none
// a waiting result sits in the output register while the next request is taken
`timescale 1ns / 1ps
`default_nettype none

`include "sorted_primary_key_index_macros.svh"

module sorted_primary_key_index
    import spki_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    input  wire t_req i_req,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_rsp      o_rsp
);

    t_ram_cmd         w_ram;
    t_ctl_stat        w_stat;
    t_rsp             w_rsp;
    logic [RAM_W-1:0] w_rd_data;
    logic             w_rsp_stall;
    logic             w_load;

    logic             r_out_valid;
    t_rsp             r_rsp;

    // keys and offsets live side by side in one ram word
    spki_ram #(
        .WIDTH(RAM_W),
        .DEPTH(TABLE_DEPTH)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (w_ram.wr_en),
        .i_wr_addr(w_ram.wr_addr),
        .i_wr_data(w_ram.wr_data),
        .i_rd_addr(w_ram.rd_addr),
        .o_rd_data(w_rd_data)
    );

    // a read whose data the sequencer uses never meets a write to the same entry in back-to-back cycles
    spki_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(i_valid),
        .i_req      (i_req),
        .i_rsp_stall(w_rsp_stall),
        .i_rd_data  (w_rd_data),
        .o_ram      (w_ram),
        .o_stat     (w_stat),
        .o_rsp      (w_rsp)
    );

    // output register is free when empty or being taken this cycle
    assign w_rsp_stall = r_out_valid && i_stall;
    assign w_load      = w_stat.done && !w_rsp_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
        if (w_load) begin
            r_rsp <= w_rsp;
        end
    end

    // only an idle sequencer takes a request
    assign o_stall = w_stat.busy;
    assign o_valid = r_out_valid;
    assign o_rsp   = r_rsp;

    // an accepted request always starts the sequencer
    `SPKI_ASSERT_NXT(a_accept_busy, i_valid && !o_stall, w_stat.busy)
    // a finished result reaches the output register
    `SPKI_ASSERT_NXT(a_load_valid, w_load, o_valid)
    // the entry count never passes the table depth
    `SPKI_ASSERT_IMP(a_count_bound, w_stat.done, w_stat.count <= CW'(TABLE_DEPTH))

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// self-checking testbench for the sorted primary key index table
`timescale 1ns / 1ps

module tb_top;
    import spki_pkg::*;

    // the unused kind value, which the block ignores
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam int HALF_PERIOD   = 2;
    localparam int RESET_CYCLES  = 4;
    localparam int RANDOM_ROUNDS = 5;
    localparam int ROUND_ITEMS   = 200;
    localparam int QUIET_TAIL    = 150;   // last requests run with no idling
    localparam int HOLD_AT       = 300;   // random request index that starts the long hold
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 300;
    localparam int TIME_LIMIT_NS = 4_000_000;
    localparam int MAX_REPORTS   = 10;

    // ---------------------------------------------------------------------
    // expected behaviour of the index table, kept in step with accepted
    // requests, and the queue of results still owed by the block
    // ---------------------------------------------------------------------
    class index_table_model;
        logic [95:0] keys[TABLE_DEPTH];
        logic [31:0] offsets[TABLE_DEPTH];
        int          used;
        int          peak_used;
        t_rsp        awaited_results[$];
        int          errors;
        int          checked;
        int          kind_seen[4];
        int          status_seen[4];

        function new();
            used      = 0;
            peak_used = 0;
            errors    = 0;
            checked   = 0;
            for (int i = 0; i < 4; i++) begin
                kind_seen[i]   = 0;
                status_seen[i] = 0;
            end
        endfunction

        // bytes past the key length or past the first zero byte do not count
        function logic [95:0] trim_key(logic [95:0] raw);
            logic [95:0] k;
            bit          ended;
            k     = raw;
            ended = 1'b0;
            for (int i = 0; i < 12; i++) begin
                if (ended || i >= KEY_BYTES) begin
                    k[95-8*i -: 8] = 8'h00;
                end
                if (k[95-8*i -: 8] == 8'h00) begin
                    ended = 1'b1;
                end
            end
            return k;
        endfunction

        // first slot whose key is not below k
        function int find_slot(logic [95:0] k);
            int lo;
            int hi;
            int mid;
            lo = 0;
            hi = used;
            while (lo < hi) begin
                mid = (lo + hi) / 2;
                if (keys[mid] < k) begin
                    lo = mid + 1;
                end else begin
                    hi = mid;
                end
            end
            return lo;
        endfunction

        function t_rsp predict_result(t_req r);
            t_rsp        rsp;
            logic [95:0] k;
            int          p;
            bit          hit;
            k   = trim_key({r.key_head, r.key_tail});
            p   = find_slot(k);
            hit = (p < used) && (keys[p] == k);
            rsp.status       = ST_NOT_FOUND;
            rsp.position     = '0;
            rsp.found_offset = '0;
            case (r.kind)
                KIND_INSERT: begin
                    if (hit) begin
                        rsp.status   = ST_DUPLICATE;
                        rsp.position = 6'(p);
                    end else if (used >= TABLE_DEPTH) begin
                        rsp.status = ST_FULL;
                    end else begin
                        for (int i = used; i > p; i--) begin
                            keys[i]    = keys[i-1];
                            offsets[i] = offsets[i-1];
                        end
                        keys[p]      = k;
                        offsets[p]   = r.record_offset;
                        used++;
                        rsp.status   = ST_OK;
                        rsp.position = 6'(p);
                    end
                end
                KIND_DELETE: begin
                    if (hit) begin
                        for (int i = p; i + 1 < used; i++) begin
                            keys[i]    = keys[i+1];
                            offsets[i] = offsets[i+1];
                        end
                        used--;
                        rsp.status   = ST_OK;
                        rsp.position = 6'(p);
                    end
                end
                KIND_LOOKUP: begin
                    if (hit) begin
                        rsp.status       = ST_OK;
                        rsp.position     = 6'(p);
                        rsp.found_offset = offsets[p];
                    end
                end
                default: begin
                end
            endcase
            rsp.entries_used = 7'(used);
            if (used > peak_used) begin
                peak_used = used;
            end
            return rsp;
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= MAX_REPORTS) begin
                $display("%s", msg);
            end
        endfunction

        function void note_request(t_req r);
            t_rsp want;
            want = predict_result(r);
            kind_seen[r.kind]++;
            status_seen[want.status]++;
            awaited_results = {awaited_results, want};
        endfunction

        function void check_result(t_rsp got);
            t_rsp want;
            if (awaited_results.size() == 0) begin
                report($sformatf("unexpected result: status %0d position %0d offset %h used %0d",
                                 got.status, got.position, got.found_offset, got.entries_used));
                return;
            end
            want = awaited_results.pop_front();
            checked++;
            if (got.status !== want.status || got.position !== want.position ||
                got.found_offset !== want.found_offset ||
                got.entries_used !== want.entries_used) begin
                report($sformatf({"result %0d mismatch: expected status %0d position %0d ",
                                  "offset %h used %0d, got status %0d position %0d ",
                                  "offset %h used %0d"},
                                 checked, want.status, want.position, want.found_offset,
                                 want.entries_used, got.status, got.position,
                                 got.found_offset, got.entries_used));
            end
        endfunction
    endclass

    // ---------------------------------------------------------------------
    // block and its signals
    // ---------------------------------------------------------------------
    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_req i_req;
    logic o_valid;
    logic i_stall;
    t_rsp o_rsp;

    index_table_model model = new();

    int cycle = 0;
    int sent = 0;
    bit quiet = 1'b0;          // set for the tail of the run: no idling on either side
    bit sender_idles = 1'b1;
    bit hold_request = 1'b0;   // sender asks the result side for the long hold

    sorted_primary_key_index dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_rsp   (o_rsp)
    );

    always begin
        #(HALF_PERIOD) i_clk = 1'b1;
        #(HALF_PERIOD) i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle <= cycle + 1;
    end

    // results are taken at the rising edge when valid and not stalled
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            model.check_result(o_rsp);
        end
    end

    // ---------------------------------------------------------------------
    // key generation
    // ---------------------------------------------------------------------

    // fill the bytes after the terminator with rubbish: same key once trimmed
    function automatic logic [95:0] scramble_after_end(logic [95:0] k);
        logic [95:0] res;
        bit          ended;
        res   = k;
        ended = 1'b0;
        for (int i = 0; i < 12; i++) begin
            if (ended) begin
                res[95-8*i -: 8] = 8'($urandom);
            end else if (res[95-8*i -: 8] == 8'h00) begin
                ended = 1'b1;
            end
        end
        return res;
    endfunction

    function automatic logic [95:0] fresh_key();
        logic [95:0] k;
        int          len;
        int          pos;
        k = {$urandom, $urandom, $urandom};
        case ($urandom_range(0, 3))
            0: begin
                // fully random bits, zero bytes land anywhere
            end
            1: begin
                // short key over a tiny alphabet, so prefixes collide often
                len = $urandom_range(1, 11);
                for (int i = 0; i < len; i++) begin
                    k[95-8*i -: 8] = 8'(8'h61 + $urandom_range(0, 3));
                end
                k[95-8*len -: 8] = 8'h00;
            end
            2: begin
                // neighbour of a stored key, one byte changed
                if (model.used > 0) begin
                    k   = model.keys[$urandom_range(0, model.used - 1)];
                    pos = $urandom_range(0, 11);
                    k[95-8*pos -: 8] = 8'($urandom);
                end
            end
            default: begin
                // full length key with no terminator
                for (int i = 0; i < 12; i++) begin
                    k[95-8*i -: 8] = 8'($urandom_range(1, 255));
                end
            end
        endcase
        return k;
    endfunction

    function automatic logic [95:0] pick_key(bit want_hit);
        if (want_hit && model.used > 0) begin
            return scramble_after_end(model.keys[$urandom_range(0, model.used - 1)]);
        end
        return fresh_key();
    endfunction

    // ---------------------------------------------------------------------
    // request side: drive at the falling edge, accept at the rising edge
    // ---------------------------------------------------------------------
    task automatic send_op(logic [1:0] kind, logic [95:0] raw, logic [31:0] offset);
        t_req r;
        int   gap;
        r.kind          = kind;
        r.key_head      = raw[95:32];
        r.key_tail      = raw[31:0];
        r.record_offset = offset;
        gap = 0;
        if (!quiet && sender_idles && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
        end
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_req   <= r;
        do @(posedge i_clk); while (o_stall);
        model.note_request(r);
        sent++;
    endtask

    // ---------------------------------------------------------------------
    // result side: random stall bursts, quiet stretches and one long hold
    // ---------------------------------------------------------------------
    initial begin : result_side
        int burst;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                // long hold so the block fills up and stalls its request side
                hold_request = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else if (!quiet && (cycle / 200) % 3 != 0 && $urandom_range(0, 4) == 0) begin
                burst = $urandom_range(1, 5);
                i_stall <= 1'b1;
                repeat (burst - 1) @(negedge i_clk);
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------------
    initial begin : request_side
        int         idx;
        int         roll;
        int         ins_lim;
        int         look_lim;
        logic [1:0] kind;
        bit         want_hit;

        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_req   = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part: empty table, extreme keys, terminator handling,
        // duplicates, tail-only difference and the ignored kind
        send_op(KIND_LOOKUP, 96'h0, 32'h0);                              // miss on empty table
        send_op(KIND_DELETE, '1, 32'hFFFF_FFFF);                         // delete on empty table
        send_op(KIND_INSERT, 96'h0, 32'h0);                              // empty key, lowest
        send_op(KIND_INSERT, '1, 32'hFFFF_FFFF);                         // highest key
        send_op(KIND_LOOKUP, '1, 32'h0);
        send_op(KIND_INSERT, {8'h00, {11{8'hA5}}}, 32'h1111_1111);       // trims to empty key
        send_op(KIND_INSERT, {8'h41, 8'h00, 80'h1234_5678_9ABC_DEF0_1357}, 32'h0000_0041);
        send_op(KIND_INSERT, {8'h41, 8'h00, {10{8'hFF}}}, 32'h2222_2222); // same key, other rubbish
        send_op(KIND_INSERT, {8'h41, 8'h42, 80'h0}, 32'h0000_4142);      // longer key after prefix
        send_op(KIND_INSERT, {64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFE}, 32'h8000_0000);
        send_op(KIND_LOOKUP, {64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFE}, 32'h0);
        send_op(KIND_UNUSED, '1, 32'hFFFF_FFFF);                         // ignored, table intact
        send_op(KIND_LOOKUP, {8'h41, 8'h00, {10{8'h5A}}}, 32'h0);
        send_op(KIND_INSERT, {8'h80, {11{8'h7F}}}, 32'h7FFF_FFFF);
        send_op(KIND_DELETE, 96'h0, 32'h0);                              // first entry
        send_op(KIND_DELETE, '1, 32'h0);                                 // last entry
        send_op(KIND_DELETE, '1, 32'h0);                                 // already gone
        send_op(KIND_LOOKUP, {8'h41, 8'h42, 8'h00, {9{8'hC3}}}, 32'h0);
        send_op(KIND_DELETE, {8'h41, 88'h0}, 32'h0);                     // first entry again
        send_op(KIND_LOOKUP, {8'h41, 88'h0}, 32'h0);

        // random part: rounds that fill, mix and drain the table, so the
        // full and empty cases both come up many times
        for (int round = 0; round < RANDOM_ROUNDS; round++) begin
            case (round % 5)
                0, 3: begin
                    ins_lim  = 70;
                    look_lim = 82;
                end
                1: begin
                    ins_lim  = 40;
                    look_lim = 70;
                end
                default: begin
                    ins_lim  = 15;
                    look_lim = 45;
                end
            endcase
            for (int n = 0; n < ROUND_ITEMS; n++) begin
                idx          = round * ROUND_ITEMS + n;
                quiet        = (idx >= RANDOM_ROUNDS * ROUND_ITEMS - QUIET_TAIL);
                sender_idles = ((idx / 40) % 3 != 2);
                if (idx == HOLD_AT) begin
                    hold_request = 1'b1;
                end
                roll = $urandom_range(0, 99);
                if (roll < ins_lim) begin
                    kind = KIND_INSERT;
                end else if (roll < look_lim) begin
                    kind = KIND_LOOKUP;
                end else if (roll < 97) begin
                    kind = KIND_DELETE;
                end else begin
                    kind = KIND_UNUSED;
                end
                // inserts mostly bring new keys, deletes and lookups mostly stored ones
                if (kind == KIND_INSERT) begin
                    want_hit = ($urandom_range(0, 4) == 0);
                end else begin
                    want_hit = ($urandom_range(0, 3) != 0);
                end
                send_op(kind, pick_key(want_hit), $urandom);
            end
        end

        @(negedge i_clk);
        i_valid <= 1'b0;

        // wait for every owed result, then watch for strays
        while (model.awaited_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d requests checked: %0d inserts, %0d deletes, %0d lookups, %0d ignored",
                 model.checked, model.kind_seen[KIND_INSERT], model.kind_seen[KIND_DELETE],
                 model.kind_seen[KIND_LOOKUP], model.kind_seen[KIND_UNUSED]);
        $display({"outcomes: %0d ok, %0d not found, %0d duplicate, %0d full; ",
                  "peak %0d entries, %0d errors"},
                 model.status_seen[ST_OK], model.status_seen[ST_NOT_FOUND],
                 model.status_seen[ST_DUPLICATE], model.status_seen[ST_FULL],
                 model.peak_used, model.errors);
        if (model.errors == 0 && model.awaited_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // hard limit on the run, several times the slowest correct run
    initial begin : watchdog
        #(TIME_LIMIT_NS);
        $display("timeout: %0d requests sent, %0d results outstanding",
                 sent, model.awaited_results.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
